// File: hw/rtl/m3nr_pkg.sv
// Package for the masked 3-D neighborhood range filter.
// Payload, configuration and control types shared by the m3nr modules other than m3nr_ram.
`timescale 1ns / 1ps
`default_nettype none

package m3nr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DEPTH_W  = 16;
    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;

    // Register indexes (byte address / 8)
    localparam logic [2:0] REG_VOLUME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_VOLUME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_VOLUME_DEPTH   = 3'd2;
    localparam logic [2:0] REG_KERNEL_WIDTH   = 3'd3;
    localparam logic [2:0] REG_KERNEL_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_KERNEL_DEPTH   = 3'd5;
    localparam logic [2:0] REG_FOOTPRINT_BITS = 3'd6;
    localparam logic [2:0] REG_SIGNED_SAMPLES = 3'd7;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] range_value;
        logic                last_voxel;
    } t_out;

    typedef struct packed {
        logic [7:0]         volume_width;
        logic [7:0]         volume_height;
        logic [DEPTH_W-1:0] volume_depth;
        logic [2:0]         kernel_width;
        logic [2:0]         kernel_height;
        logic [2:0]         kernel_depth;
        logic [63:0]        footprint_bits;
        logic               signed_samples;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BASE_Z,
        ST_BASE_Y,
        ST_BASE_X,
        ST_CENTER,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic base_z;
        logic base_y;
        logic base_x;
        logic center;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic ready;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/m3nr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module m3nr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/m3nr_cfg.sv
// APB register bank for the range filter: eight registers at 8-byte steps.
// Uses m3nr_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module m3nr_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [m3nr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [m3nr_pkg::APB_DW-1:0]   pwdata,
    output logic      [m3nr_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output m3nr_pkg::t_cfg                     o_cfg,
    output logic                               o_restart
);

    m3nr_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[5:3];
    assign wr_en     = psel && penable && pwrite;
    assign o_restart = wr_en;
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume_width   <= 8'd1;
            r_cfg.volume_height  <= 8'd1;
            r_cfg.volume_depth   <= 16'd1;
            r_cfg.kernel_width   <= 3'd1;
            r_cfg.kernel_height  <= 3'd1;
            r_cfg.kernel_depth   <= 3'd1;
            r_cfg.footprint_bits <= 64'd1;
            r_cfg.signed_samples <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                m3nr_pkg::REG_VOLUME_WIDTH:   r_cfg.volume_width   <= pwdata[7:0];
                m3nr_pkg::REG_VOLUME_HEIGHT:  r_cfg.volume_height  <= pwdata[7:0];
                m3nr_pkg::REG_VOLUME_DEPTH:   r_cfg.volume_depth   <= pwdata[15:0];
                m3nr_pkg::REG_KERNEL_WIDTH:   r_cfg.kernel_width   <= pwdata[2:0];
                m3nr_pkg::REG_KERNEL_HEIGHT:  r_cfg.kernel_height  <= pwdata[2:0];
                m3nr_pkg::REG_KERNEL_DEPTH:   r_cfg.kernel_depth   <= pwdata[2:0];
                m3nr_pkg::REG_FOOTPRINT_BITS: r_cfg.footprint_bits <= pwdata;
                m3nr_pkg::REG_SIGNED_SAMPLES: r_cfg.signed_samples <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            m3nr_pkg::REG_VOLUME_WIDTH:   prdata = 64'(r_cfg.volume_width);
            m3nr_pkg::REG_VOLUME_HEIGHT:  prdata = 64'(r_cfg.volume_height);
            m3nr_pkg::REG_VOLUME_DEPTH:   prdata = 64'(r_cfg.volume_depth);
            m3nr_pkg::REG_KERNEL_WIDTH:   prdata = 64'(r_cfg.kernel_width);
            m3nr_pkg::REG_KERNEL_HEIGHT:  prdata = 64'(r_cfg.kernel_height);
            m3nr_pkg::REG_KERNEL_DEPTH:   prdata = 64'(r_cfg.kernel_depth);
            m3nr_pkg::REG_FOOTPRINT_BITS: prdata = r_cfg.footprint_bits;
            m3nr_pkg::REG_SIGNED_SAMPLES: prdata = 64'(r_cfg.signed_samples);
            default:                      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/m3nr_ctrl.sv
// Sequencer for the range filter: one request at a time, then a window scan when a result is due.
// Uses m3nr_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module m3nr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  m3nr_pkg::t_status      i_status,
    output m3nr_pkg::t_cmd         o_cmd
);

    m3nr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= m3nr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            m3nr_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = m3nr_pkg::ST_CHECK;
                end
            end
            m3nr_pkg::ST_CHECK: begin
                // a result is due only once its whole window is written
                n_state = i_status.ready ? m3nr_pkg::ST_BASE_Z : m3nr_pkg::ST_IDLE;
            end
            m3nr_pkg::ST_BASE_Z: begin
                o_cmd.base_z = 1'b1;
                n_state      = m3nr_pkg::ST_BASE_Y;
            end
            m3nr_pkg::ST_BASE_Y: begin
                o_cmd.base_y = 1'b1;
                n_state      = m3nr_pkg::ST_BASE_X;
            end
            m3nr_pkg::ST_BASE_X: begin
                o_cmd.base_x = 1'b1;
                n_state      = m3nr_pkg::ST_CENTER;
            end
            m3nr_pkg::ST_CENTER: begin
                o_cmd.center = 1'b1;
                n_state      = m3nr_pkg::ST_SCAN;
            end
            m3nr_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = m3nr_pkg::ST_DRAIN;
                end
            end
            m3nr_pkg::ST_DRAIN: begin
                n_state = m3nr_pkg::ST_DONE;
            end
            m3nr_pkg::ST_DONE: begin
                // hold until the output register can take the result
                o_cmd.finish = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = m3nr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = m3nr_pkg::ST_IDLE;
            end
        endcase
    end

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == m3nr_pkg::ST_IDLE && i_in_valid) |=> (r_state == m3nr_pkg::ST_CHECK))
        else $error("accepted request did not move to check");

    a_scan_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == m3nr_pkg::ST_SCAN && i_status.scan_last) |=>
        (r_state == m3nr_pkg::ST_DRAIN))
        else $error("scan did not end on its last cell");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == m3nr_pkg::ST_DONE && i_status.out_free) |=>
        (r_state == m3nr_pkg::ST_IDLE))
        else $error("finished result not released");

    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != m3nr_pkg::ST_IDLE) |-> (o_in_stall && !o_cmd.accept))
        else $error("request taken while busy");

endmodule

`default_nettype wire

// File: hw/rtl/m3nr_dp.sv
// Datapath of the range filter: positions, window store, address walk, min/max.
// Uses m3nr_pkg types and instantiates m3nr_ram.
`timescale 1ns / 1ps
`default_nettype none

module m3nr_dp #(
    parameter int MAX_KERNEL = 4,
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  m3nr_pkg::t_cfg      i_cfg,
    input  wire logic           i_restart,
    input  m3nr_pkg::t_cmd      i_cmd,
    output m3nr_pkg::t_status   o_status,
    input  m3nr_pkg::t_in       i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output m3nr_pkg::t_out      o_out_data
);

    localparam int DEPTH = MAX_KERNEL * MAX_WIDTH * MAX_HEIGHT;
    localparam int AB    = $clog2(DEPTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int KB    = $clog2(MAX_KERNEL + 1);
    localparam int PB    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int ZB    = m3nr_pkg::DEPTH_W;
    localparam int SW    = m3nr_pkg::SAMPLE_W;

    function automatic logic [AB-1:0] wrap_add(input logic [AB-1:0] a,
                                               input logic [AB-1:0] b);
        logic [AB:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AB+1)'(DEPTH)) begin
            s = s - (AB+1)'(DEPTH);
        end
        return s[AB-1:0];
    endfunction

    function automatic logic [AB-1:0] wrap_sub(input logic [AB-1:0] a,
                                               input logic [AB-1:0] b);
        logic [AB:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (s[AB]) begin
            s = s + (AB+1)'(DEPTH);
        end
        return s[AB-1:0];
    endfunction

    function automatic logic [AB-1:0] reduce(input logic [AB:0] v);
        logic [AB:0] s;
        s = v;
        if (s >= (AB+1)'(DEPTH)) begin
            s = s - (AB+1)'(DEPTH);
        end
        return s[AB-1:0];
    endfunction

    function automatic logic [KB-1:0] clamp_k(input logic [2:0] v);
        logic [KB-1:0] k;
        if (v == 3'd0) begin
            k = KB'(1);
        end else if (int'(v) > MAX_KERNEL) begin
            k = KB'(MAX_KERNEL);
        end else begin
            k = KB'(v);
        end
        return k;
    endfunction

    function automatic logic less(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                  input logic sgn);
        return sgn ? ($signed(a) < $signed(b)) : (a < b);
    endfunction

    // Clamped sizes
    logic [WB-1:0] w_size, w_max;
    logic [HB-1:0] h_size, h_max;
    logic [ZB-1:0] d_size, d_max;
    logic [KB-1:0] kw, kh, kd, hx, hy, hz, tx, ty, tz;

    always_comb begin
        if (i_cfg.volume_width == 8'd0) begin
            w_size = WB'(1);
        end else if (int'(i_cfg.volume_width) > MAX_WIDTH) begin
            w_size = WB'(MAX_WIDTH);
        end else begin
            w_size = WB'(i_cfg.volume_width);
        end
        if (i_cfg.volume_height == 8'd0) begin
            h_size = HB'(1);
        end else if (int'(i_cfg.volume_height) > MAX_HEIGHT) begin
            h_size = HB'(MAX_HEIGHT);
        end else begin
            h_size = HB'(i_cfg.volume_height);
        end
        d_size = (i_cfg.volume_depth == '0) ? ZB'(1) : i_cfg.volume_depth;
    end

    assign w_max = w_size - WB'(1);
    assign h_max = h_size - HB'(1);
    assign d_max = d_size - ZB'(1);
    assign kw    = clamp_k(i_cfg.kernel_width);
    assign kh    = clamp_k(i_cfg.kernel_height);
    assign kd    = clamp_k(i_cfg.kernel_depth);
    assign hx    = kw >> 1;
    assign hy    = kh >> 1;
    assign hz    = kd >> 1;
    assign tx    = kw - KB'(1) - hx;
    assign ty    = kh - KB'(1) - hy;
    assign tz    = kd - KB'(1) - hz;

    // Plane size registered; config must only change while idle, which the user ensures (not enforced here)
    logic [PB-1:0] r_plane_size;
    logic [AB-1:0] row_step, plane_step;

    always_ff @(posedge i_clk) begin
        r_plane_size <= PB'(w_size) * PB'(h_size);
    end

    assign row_step   = reduce((AB+1)'(w_size));
    assign plane_step = reduce((AB+1)'(r_plane_size));

    // Positions and addresses
    logic [WB-1:0] r_wx, r_ex;
    logic [HB-1:0] r_wy, r_ey;
    logic [ZB-1:0] r_wz, r_ez;
    logic [AB-1:0] r_waddr, r_eaddr;
    logic [AB-1:0] r_base, r_plane, r_row, r_addr;
    logic [KB-1:0] r_kx, r_ky, r_kz;
    logic          r_rd_vld, r_rd_first;
    logic [SW-1:0] r_lo, r_hi;
    logic          r_out_valid;
    m3nr_pkg::t_out r_out;

    logic          wr_en, last_emit, out_free;
    logic [SW-1:0] rd_data;
    logic [AB-1:0] rd_addr;

    assign wr_en = i_cmd.accept && (i_in_data.action == m3nr_pkg::ACT_SAMPLE)
                   && (r_wz < d_size);

    m3nr_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_waddr),
        .i_wdata (i_in_data.sample),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Result is due when the last voxel of its window precedes the write point
    logic [WB:0]   nx_raw;
    logic [HB:0]   ny_raw;
    logic [ZB:0]   nz_raw;
    logic [WB-1:0] nx;
    logic [HB-1:0] ny;
    logic [ZB-1:0] nz;

    always_comb begin
        nx_raw = (WB+1)'(r_ex) + (WB+1)'(tx);
        ny_raw = (HB+1)'(r_ey) + (HB+1)'(ty);
        nz_raw = (ZB+1)'(r_ez) + (ZB+1)'(tz);
        nx = (nx_raw > (WB+1)'(w_max)) ? w_max : nx_raw[WB-1:0];
        ny = (ny_raw > (HB+1)'(h_max)) ? h_max : ny_raw[HB-1:0];
        nz = (nz_raw > (ZB+1)'(d_max)) ? d_max : nz_raw[ZB-1:0];
    end

    // Neighbor cell in volume and enabled in the footprint
    logic [WB+1:0] sx;
    logic [HB+1:0] sy;
    logic [ZB+1:0] sz;
    logic          cell_ok, scan_last;
    int            bit_idx;

    always_comb begin
        sx = (WB+2)'(r_ex) + (WB+2)'(r_kx);
        sy = (HB+2)'(r_ey) + (HB+2)'(r_ky);
        sz = (ZB+2)'(r_ez) + (ZB+2)'(r_kz);
        bit_idx = int'(r_kx) + MAX_KERNEL * int'(r_ky)
                  + MAX_KERNEL * MAX_KERNEL * int'(r_kz);
        cell_ok = (sx >= (WB+2)'(hx)) && (sx < (WB+2)'(w_size) + (WB+2)'(hx))
               && (sy >= (HB+2)'(hy)) && (sy < (HB+2)'(h_size) + (HB+2)'(hy))
               && (sz >= (ZB+2)'(hz)) && (sz < (ZB+2)'(d_size) + (ZB+2)'(hz))
               && (bit_idx < 64) && i_cfg.footprint_bits[bit_idx[5:0]];
        scan_last = (r_kx == kw - KB'(1)) && (r_ky == kh - KB'(1))
                 && (r_kz == kd - KB'(1));
    end

    assign rd_addr   = i_cmd.center ? r_eaddr : r_addr;
    assign last_emit = (r_ex == w_max) && (r_ey == h_max) && (r_ez == d_max);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_status.ready = (nz < r_wz) ||
                            (nz == r_wz && (ny < r_wy || (ny == r_wy && nx < r_wx)));
    assign o_status.scan_last = scan_last;
    assign o_status.out_free  = out_free;

    // Write and emit positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || (i_cmd.finish && last_emit)) begin
            r_wx    <= '0;
            r_wy    <= '0;
            r_wz    <= '0;
            r_waddr <= '0;
            r_ex    <= '0;
            r_ey    <= '0;
            r_ez    <= '0;
            r_eaddr <= '0;
        end else begin
            if (wr_en) begin
                r_waddr <= wrap_add(r_waddr, AB'(1));
                if (r_wx == w_max) begin
                    r_wx <= '0;
                    if (r_wy == h_max) begin
                        r_wy <= '0;
                        r_wz <= r_wz + ZB'(1);
                    end else begin
                        r_wy <= r_wy + HB'(1);
                    end
                end else begin
                    r_wx <= r_wx + WB'(1);
                end
            end
            if (i_cmd.finish) begin
                r_eaddr <= wrap_add(r_eaddr, AB'(1));
                if (r_ex == w_max) begin
                    r_ex <= '0;
                    if (r_ey == h_max) begin
                        r_ey <= '0;
                        r_ez <= r_ez + ZB'(1);
                    end else begin
                        r_ey <= r_ey + HB'(1);
                    end
                end else begin
                    r_ex <= r_ex + WB'(1);
                end
            end
        end
    end

    // Window walk: low corner first, then x, y, z
    logic [AB+KB:0] z_off, y_off;
    logic [AB-1:0]  nxt_row, nxt_plane;

    assign z_off     = (AB+KB+1)'(hz) * (AB+KB+1)'(r_plane_size);
    assign y_off     = (AB+KB+1)'(hy) * (AB+KB+1)'(w_size);
    assign nxt_row   = wrap_add(r_row, row_step);
    assign nxt_plane = wrap_add(r_plane, plane_step);

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_z) begin
            r_base <= wrap_sub(r_eaddr, z_off[AB-1:0]);
        end else if (i_cmd.base_y) begin
            r_base <= wrap_sub(r_base, y_off[AB-1:0]);
        end else if (i_cmd.base_x) begin
            r_base <= wrap_sub(r_base, AB'(hx));
        end
        if (i_cmd.center) begin
            r_plane <= r_base;
            r_row   <= r_base;
            r_addr  <= r_base;
            r_kx    <= '0;
            r_ky    <= '0;
            r_kz    <= '0;
        end else if (i_cmd.scan) begin
            if (r_kx != kw - KB'(1)) begin
                r_kx   <= r_kx + KB'(1);
                r_addr <= wrap_add(r_addr, AB'(1));
            end else begin
                r_kx <= '0;
                if (r_ky != kh - KB'(1)) begin
                    r_ky   <= r_ky + KB'(1);
                    r_row  <= nxt_row;
                    r_addr <= nxt_row;
                end else begin
                    r_ky    <= '0;
                    r_kz    <= r_kz + KB'(1);
                    r_plane <= nxt_plane;
                    r_row   <= nxt_plane;
                    r_addr  <= nxt_plane;
                end
            end
        end
    end

    // Min/max over returned reads; the center read seeds both
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.center || (i_cmd.scan && cell_ok);
            r_rd_first <= i_cmd.center;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_first) begin
                r_lo <= rd_data;
                r_hi <= rd_data;
            end else begin
                if (less(rd_data, r_lo, i_cfg.signed_samples)) begin
                    r_lo <= rd_data;
                end
                if (less(r_hi, rd_data, i_cfg.signed_samples)) begin
                    r_hi <= rd_data;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.range_value <= r_hi - r_lo;
            r_out.last_voxel  <= last_emit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/masked_3d_neighborhood_range.sv
// Top level of the masked 3-D neighborhood range filter.
// Instantiates m3nr_cfg, m3nr_ctrl and m3nr_dp; types from m3nr_pkg.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_stall      i_in_data  (action, sample)
//   output    out        o_out_valid / i_out_stall    o_out_data (range_value, last_voxel)
//   config    in         APB psel/penable/pwrite      paddr = 8*index, 64-bit data
//
// A request with no result due makes no window-store reads; otherwise it makes one
// read per kernel cell plus the center read, all through the single read port of
// the window store, which issues them in turn.
// Reset is synchronous; the store is not cleared and needs no clearing pass.
// One result waits in the output register while the next request is taken;
// a second result holds the sequencer until the first one is taken.
`timescale 1ns / 1ps
`default_nettype none

module masked_3d_neighborhood_range #(
    parameter int MAX_KERNEL = 4,
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  m3nr_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output m3nr_pkg::t_out                     o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [m3nr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [m3nr_pkg::APB_DW-1:0]   pwdata,
    output logic      [m3nr_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    m3nr_pkg::t_cfg    cfg;
    m3nr_pkg::t_cmd    cmd;
    m3nr_pkg::t_status status;
    logic              restart;

    m3nr_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    m3nr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    m3nr_dp #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_restart   (restart),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
